/* rtl/fbba_pkg.sv */
// Shared constants and types for the fixed block buffer allocator.
`default_nettype none

package fbba_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int RING_AW    = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = RING_AW + 1;
  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 21;
  localparam int PROD_W     = SIZE_W + RING_AW;
  localparam int DIV_STEPS  = ADDR_W;
  localparam int DIV_CW     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;

  localparam logic [ADDR_W-1:0] BASE_RST  = '0;
  localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(4096);
  localparam logic [CNT_W-1:0]  COUNT_RST = CNT_W'(MAX_BLOCKS);

  typedef enum logic {
    FUNC_GET     = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_COUNT = 2'd2
  } reg_idx_e;

endpackage

`default_nettype wire

/* rtl/fbba_if.sv */
// Request and response channel interfaces of the allocator.
`default_nettype none

interface fbba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [fbba_pkg::ADDR_W-1:0]  release_address;

  modport source (output valid, output func, output release_address, input ready);
  modport sink   (input valid, input func, input release_address, output ready);
endinterface

interface fbba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fbba_pkg::ADDR_W-1:0]  block_address;
  logic [1:0]                   status;

  modport source (output valid, output block_address, output status, input ready);
  modport sink   (input valid, input block_address, input status, output ready);
endinterface

`default_nettype wire

/* rtl/fixed_block_buffer_allocator_core.sv */
// Fixed-size block allocator with a FIFO free ring held in a synchronous RAM.
//
// One item is handled at a time. A get passes through a ring RAM read, a
// size-by-index multiply and the base add before it loads the result
// register. A release runs the restoring divider, which retires one quotient
// bit per cycle over the 48 address bits, then the range check. The next
// item can be accepted in the cycle after the result register is loaded.
// The result register lets a new item be accepted while the last result
// waits. No clearing pass is needed after reset or a block count write:
// until the first block_count entries have been handed out, a get returns
// the read position itself rather than the RAM word.
`default_nettype none

module fixed_block_buffer_allocator_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [fbba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [fbba_pkg::ADDR_W-1:0]         cfg_wdata_i,
  fbba_req_if.sink                           req,
  fbba_rsp_if.source                         rsp
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_GET_RD  = 6'b000010,
    ST_GET_ADD = 6'b000100,
    ST_DIV     = 6'b001000,
    ST_CHECK   = 6'b010000,
    ST_DONE    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [fbba_pkg::ADDR_W-1:0]  base_q, base_d;
  logic [fbba_pkg::SIZE_W-1:0]  size_q, size_d;
  logic [fbba_pkg::CNT_W-1:0]   count_q, count_d;

  logic [fbba_pkg::RING_AW-1:0] rp_q, rp_d;
  logic [fbba_pkg::RING_AW-1:0] wp_q, wp_d;
  logic [fbba_pkg::CNT_W-1:0]   fcnt_q, fcnt_d;
  logic [fbba_pkg::CNT_W-1:0]   rdcnt_q, rdcnt_d;

  logic [fbba_pkg::ADDR_W-1:0]  quo_q, quo_d;
  logic [fbba_pkg::SIZE_W-1:0]  rem_q, rem_d;
  logic [fbba_pkg::DIV_CW-1:0]  step_q, step_d;
  logic [fbba_pkg::PROD_W-1:0]  prod_q, prod_d;

  logic [fbba_pkg::ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic [1:0]                   res_status_q, res_status_d;

  logic                         rsp_valid_q;
  logic [fbba_pkg::ADDR_W-1:0]  rsp_addr_q;
  logic [1:0]                   rsp_status_q;
  logic                         rsp_load;

  logic [fbba_pkg::RING_AW-1:0] ring [fbba_pkg::MAX_BLOCKS];
  logic [fbba_pkg::RING_AW-1:0] rdata_q;
  logic                         rd_en;
  logic                         wr_en;

  assign req.ready = (state_q == ST_IDLE);
  assign rsp.valid = rsp_valid_q;
  assign rsp.block_address = rsp_addr_q;
  assign rsp.status = rsp_status_q;

  assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

  always_comb begin
    logic [fbba_pkg::ADDR_W:0]    diff;
    logic [fbba_pkg::SIZE_W:0]    rem_t;
    logic                         ge;
    logic                         first_pass;
    logic [fbba_pkg::RING_AW-1:0] idx;
    logic                         too_big;
    logic [fbba_pkg::CNT_W-1:0]   cnt_v;

    state_d      = state_q;
    base_d       = base_q;
    size_d       = size_q;
    count_d      = count_q;
    rp_d         = rp_q;
    wp_d         = wp_q;
    fcnt_d       = fcnt_q;
    rdcnt_d      = rdcnt_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    step_d       = step_q;
    prod_d       = prod_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;

    diff       = {1'b0, req.release_address} - {1'b0, base_q};
    rem_t      = {rem_q, quo_q[fbba_pkg::ADDR_W-1]};
    ge         = (rem_t >= {1'b0, size_q});
    first_pass = (rdcnt_q < count_q);
    idx        = first_pass ? rp_q : rdata_q;
    too_big    = (|quo_q[fbba_pkg::ADDR_W-1:fbba_pkg::CNT_W]) ||
                 (quo_q[fbba_pkg::CNT_W-1:0] >= count_q);
    cnt_v      = cfg_wdata_i[fbba_pkg::CNT_W-1:0];
    if (cnt_v > fbba_pkg::CNT_W'(fbba_pkg::MAX_BLOCKS)) begin
      cnt_v = fbba_pkg::CNT_W'(fbba_pkg::MAX_BLOCKS);
    end

    case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          res_addr_d = '0;
          if (req.func == fbba_pkg::FUNC_GET) begin
            if (fcnt_q == '0) begin
              res_status_d = fbba_pkg::STAT_EMPTY;
              state_d      = ST_DONE;
            end else begin
              rd_en   = 1'b1;
              state_d = ST_GET_RD;
            end
          end else if (diff[fbba_pkg::ADDR_W] || (size_q == '0)) begin
            res_status_d = fbba_pkg::STAT_RANGE;
            state_d      = ST_DONE;
          end else begin
            quo_d   = diff[fbba_pkg::ADDR_W-1:0];
            rem_d   = '0;
            step_d  = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_GET_RD: begin
        // The RAM word is valid only once the initial sequence has been used up.
        prod_d = fbba_pkg::PROD_W'(size_q) * fbba_pkg::PROD_W'(idx);
        rp_d   = rp_q + 1'b1;
        fcnt_d = fcnt_q - 1'b1;
        if (first_pass) begin
          rdcnt_d = rdcnt_q + 1'b1;
        end
        state_d = ST_GET_ADD;
      end
      ST_GET_ADD: begin
        res_addr_d   = base_q + fbba_pkg::ADDR_W'(prod_q);
        res_status_d = fbba_pkg::STAT_OK;
        state_d      = ST_DONE;
      end
      ST_DIV: begin
        if (ge) begin
          rem_d = fbba_pkg::SIZE_W'(rem_t - {1'b0, size_q});
        end else begin
          rem_d = rem_t[fbba_pkg::SIZE_W-1:0];
        end
        quo_d  = {quo_q[fbba_pkg::ADDR_W-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == fbba_pkg::DIV_CW'(fbba_pkg::DIV_STEPS - 1)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (too_big) begin
          res_status_d = fbba_pkg::STAT_RANGE;
        end else if (fcnt_q >= count_q) begin
          res_status_d = fbba_pkg::STAT_FULL;
        end else begin
          wr_en        = 1'b1;
          wp_d         = wp_q + 1'b1;
          fcnt_d       = fcnt_q + 1'b1;
          res_status_d = fbba_pkg::STAT_OK;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        fbba_pkg::REG_BASE: begin
          base_d = cfg_wdata_i;
        end
        fbba_pkg::REG_SIZE: begin
          size_d = cfg_wdata_i[fbba_pkg::SIZE_W-1:0];
        end
        fbba_pkg::REG_COUNT: begin
          count_d = cnt_v;
          rp_d    = '0;
          wp_d    = cnt_v[fbba_pkg::RING_AW-1:0];
          fcnt_d  = cnt_v;
          rdcnt_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= fbba_pkg::BASE_RST;
      size_q      <= fbba_pkg::SIZE_RST;
      count_q     <= fbba_pkg::COUNT_RST;
      rp_q        <= '0;
      wp_q        <= fbba_pkg::COUNT_RST[fbba_pkg::RING_AW-1:0];
      fcnt_q      <= fbba_pkg::COUNT_RST;
      rdcnt_q     <= '0;
      step_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      size_q  <= size_d;
      count_q <= count_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      fcnt_q  <= fcnt_d;
      rdcnt_q <= rdcnt_d;
      step_q  <= step_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    prod_q       <= prod_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (rsp_load) begin
      rsp_addr_q   <= res_addr_q;
      rsp_status_q <= res_status_q;
    end
  end

  // Free ring RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring[wp_q] <= quo_q[fbba_pkg::RING_AW-1:0];
    end
    if (rd_en) begin
      rdata_q <= ring[rp_q];
    end
  end

endmodule

`default_nettype wire

/* rtl/fbba_checker.sv */
// Port-level assertions for the allocator and their binding to the top level.
`default_nettype none

module fbba_checker (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  input  wire                           in_ready_i,
  input  wire                           out_valid_i,
  input  wire                           out_ready_i,
  input  wire [fbba_pkg::ADDR_W-1:0]    out_addr_i,
  input  wire [1:0]                     out_status_i
);

  // Items are handled one at a time, so acceptance closes the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted in two consecutive cycles");

  // Only a successful get carries an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i != fbba_pkg::STAT_OK)) |-> (out_addr_i == '0))
    else $error("failed result carries a nonzero address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(out_addr_i) && $stable(out_status_i)))
    else $error("stalled result changed");

endmodule

bind fixed_block_buffer_allocator_core fbba_checker u_fbba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req.valid),
  .in_ready_i   (req.ready),
  .out_valid_i  (rsp.valid),
  .out_ready_i  (rsp.ready),
  .out_addr_i   (rsp.block_address),
  .out_status_i (rsp.status)
);

`default_nettype wire
